### rtl/ccb_pkg.sv
package ccb_pkg;

  localparam int FB_WIDTH_DEF  = 320;
  localparam int FB_HEIGHT_DEF = 240;

  // operation codes on the item channel
  localparam logic [1:0] FUNC_PUT  = 2'd0;
  localparam logic [1:0] FUNC_BLIT = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // register indexes, byte address = 4 * index
  localparam int          APB_AW         = 5;
  localparam logic [2:0]  REG_DEST_X     = 3'd0;
  localparam logic [2:0]  REG_DEST_Y     = 3'd1;
  localparam logic [2:0]  REG_SRC_X      = 3'd2;
  localparam logic [2:0]  REG_SRC_Y      = 3'd3;
  localparam logic [2:0]  REG_SRC_W      = 3'd4;
  localparam logic [2:0]  REG_SRC_H      = 3'd5;
  localparam logic [2:0]  REG_KEY_COLOR  = 3'd6;
  localparam logic [2:0]  REG_KEY_ENABLE = 3'd7;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [11:0] src_w;
    logic [11:0] src_h;
    logic [7:0]  key_color;
    logic        key_enable;
  } cfg_t;

  typedef struct packed {
    logic       wr;
    logic       rd;
    logic [7:0] color;
  } mem_req_t;

endpackage

### rtl/ccb_if.sv
interface ccb_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [11:0] x;
  logic signed [11:0] y;
  logic [7:0]         color;

  modport source (output valid, output func, output x, output y, output color, input ready);
  modport sink (input valid, input func, input x, input y, input color, output ready);
endinterface

interface ccb_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       written;

  modport source (output valid, output pixel, output written, input ready);
  modport sink (input valid, input pixel, input written, output ready);
endinterface

### rtl/ccb_cfg.sv
module ccb_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccb_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ccb_pkg::cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        ccb_pkg::REG_DEST_X:     cfg.dest_x     <= pwdata[11:0];
        ccb_pkg::REG_DEST_Y:     cfg.dest_y     <= pwdata[11:0];
        ccb_pkg::REG_SRC_X:      cfg.src_x      <= pwdata[11:0];
        ccb_pkg::REG_SRC_Y:      cfg.src_y      <= pwdata[11:0];
        ccb_pkg::REG_SRC_W:      cfg.src_w      <= pwdata[11:0];
        ccb_pkg::REG_SRC_H:      cfg.src_h      <= pwdata[11:0];
        ccb_pkg::REG_KEY_COLOR:  cfg.key_color  <= pwdata[7:0];
        ccb_pkg::REG_KEY_ENABLE: cfg.key_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ccb_pkg::REG_DEST_X:     prdata = {20'd0, cfg.dest_x};
      ccb_pkg::REG_DEST_Y:     prdata = {20'd0, cfg.dest_y};
      ccb_pkg::REG_SRC_X:      prdata = {20'd0, cfg.src_x};
      ccb_pkg::REG_SRC_Y:      prdata = {20'd0, cfg.src_y};
      ccb_pkg::REG_SRC_W:      prdata = {20'd0, cfg.src_w};
      ccb_pkg::REG_SRC_H:      prdata = {20'd0, cfg.src_h};
      ccb_pkg::REG_KEY_COLOR:  prdata = {24'd0, cfg.key_color};
      ccb_pkg::REG_KEY_ENABLE: prdata = {31'd0, cfg.key_enable};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

### rtl/ccb_clip.sv
module ccb_clip #(
  parameter int FB_WIDTH  = ccb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = ccb_pkg::FB_HEIGHT_DEF,
  parameter int AW        = 17
) (
  input  logic                    clk,
  input  ccb_pkg::cfg_t           cfg,
  input  logic [1:0]              func,
  input  logic [11:0]             x,
  input  logic [11:0]             y,
  input  logic [7:0]              color,
  output logic [AW-1:0]           addr,
  output ccb_pkg::mem_req_t       req
);

  localparam int XW = (FB_WIDTH > 1) ? $clog2(FB_WIDTH) : 1;
  localparam int YW = (FB_HEIGHT > 1) ? $clog2(FB_HEIGHT) : 1;
  localparam logic [12:0]   W_LIM  = 13'(FB_WIDTH);
  localparam logic [12:0]   H_LIM  = 13'(FB_HEIGHT);
  localparam logic [AW-1:0] W_MULT = AW'(FB_WIDTH);

  // first stage: texel offset inside the source rectangle
  logic [12:0] ox, oy;
  // second stage: target point and operation
  logic [13:0] px, py;
  logic        wr_ok, rd_ok;
  logic [13:0] dx, dy;
  logic        in_rect, keyed, is_blit;
  logic        on_screen;

  always_ff @(posedge clk) begin
    ox <= {x[11], x} - {cfg.src_x[11], cfg.src_x};
    oy <= {y[11], y} - {cfg.src_y[11], cfg.src_y};
  end

  always_comb begin
    in_rect = !ox[12] && (ox[11:0] < cfg.src_w) && !oy[12] && (oy[11:0] < cfg.src_h);
    keyed   = cfg.key_enable && (color == cfg.key_color);
    is_blit = (func == ccb_pkg::FUNC_BLIT);
    dx      = {cfg.dest_x[11], cfg.dest_x[11], cfg.dest_x} + {ox[12], ox};
    dy      = {cfg.dest_y[11], cfg.dest_y[11], cfg.dest_y} + {oy[12], oy};
  end

  always_ff @(posedge clk) begin
    px    <= is_blit ? dx : {{2{x[11]}}, x};
    py    <= is_blit ? dy : {{2{y[11]}}, y};
    wr_ok <= (func == ccb_pkg::FUNC_PUT) || (is_blit && in_rect && !keyed);
    rd_ok <= (func == ccb_pkg::FUNC_READ);
  end

  assign on_screen = !px[13] && (px[12:0] < W_LIM) && !py[13] && (py[12:0] < H_LIM);

  // row-major address, one multiply
  always_ff @(posedge clk) begin
    addr      <= AW'(py[YW-1:0]) * W_MULT + AW'(px[XW-1:0]);
    req.wr    <= wr_ok && on_screen;
    req.rd    <= rd_ok && on_screen;
    req.color <= color;
  end

endmodule

### rtl/ccb_fb_mem.sv
module ccb_fb_mem #(
  parameter int DEPTH = ccb_pkg::FB_WIDTH_DEF * ccb_pkg::FB_HEIGHT_DEF,
  parameter int AW    = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/clipped_color_key_blitter_unit.sv
// Indexed 8-bit framebuffer with put, read-back and clipped color-key blit of
// single texels. Items are handled one at a time: a transfer on the item
// channel runs through offset, clip, address multiply and at most one access
// of the single-port frame memory, and the next item is taken only after its
// result is loaded into the output register, which waits while an earlier
// result is still held there. Every item produces exactly one result.
// Pixels must be written before they are read back; the frame memory has no
// reset. The user must write configuration over the APB port only while no
// item is in flight; the block itself does not enforce this.
module clipped_color_key_blitter_unit #(
  parameter int FB_WIDTH  = ccb_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = ccb_pkg::FB_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  ccb_item_if.sink                   item,
  ccb_result_if.source               result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccb_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_OFFSET = 3'd1;
  localparam logic [2:0] ST_CLIP   = 3'd2;
  localparam logic [2:0] ST_ADDR   = 3'd3;
  localparam logic [2:0] ST_ACCESS = 3'd4;
  localparam logic [2:0] ST_RESULT = 3'd5;

  ccb_pkg::cfg_t     cfg;
  ccb_pkg::mem_req_t req;
  logic [AW-1:0]     addr;
  logic [7:0]        rdata;
  logic              mem_en;

  logic [2:0]  state, state_next;
  logic [1:0]  func_r;
  logic [11:0] x_r, y_r;
  logic [7:0]  color_r;
  logic        out_valid;
  logic [7:0]  pixel_r;
  logic        written_r;
  logic        item_xfer, load;

  ccb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccb_clip #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT),
    .AW        (AW)
  ) u_clip (
    .clk   (clk),
    .cfg   (cfg),
    .func  (func_r),
    .x     (x_r),
    .y     (y_r),
    .color (color_r),
    .addr  (addr),
    .req   (req)
  );

  assign mem_en = (state == ST_ACCESS) && (req.wr || req.rd);

  ccb_fb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (req.wr),
    .addr  (addr),
    .wdata (req.color),
    .rdata (rdata)
  );

  assign item.ready = (state == ST_IDLE);
  assign item_xfer  = item.valid && item.ready;
  assign load       = (state == ST_RESULT) && (!out_valid || result.ready);

  always_comb begin
    case (state)
      ST_IDLE:   state_next = item_xfer ? ST_OFFSET : ST_IDLE;
      ST_OFFSET: state_next = ST_CLIP;
      ST_CLIP:   state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_ACCESS;
      ST_ACCESS: state_next = ST_RESULT;
      ST_RESULT: state_next = load ? ST_IDLE : ST_RESULT;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the item steady while the clip stages work on it
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      func_r  <= item.func;
      x_r     <= item.x;
      y_r     <= item.y;
      color_r <= item.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r   <= req.rd ? rdata : 8'd0;
      written_r <= req.wr;
    end
  end

  assign result.valid   = out_valid;
  assign result.pixel   = pixel_r;
  assign result.written = written_r;

`ifndef SYNTHESIS
  a_xfer_starts: assert property (@(posedge clk) disable iff (rst)
    item_xfer |=> state == ST_OFFSET)
    else $error("item transfer did not start the offset step");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (mem_en && req.wr) |-> (32'(addr) < 32'(DEPTH)))
    else $error("frame write outside the frame store");

  a_read_xor_write: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.written && (result.pixel != 8'd0)))
    else $error("result shows both a write and read-back data");

  a_load_after_access: assert property (@(posedge clk) disable iff (rst)
    load |-> ($past(state) == ST_ACCESS || $past(state) == ST_RESULT))
    else $error("result loaded without a frame access");
`endif

endmodule
